/* hdl/plob_pkg.sv */
// Shared types and constants of the price-level order book.
package plob_pkg;

    localparam int LEVELS   = 64;
    localparam int IDX_W    = $clog2(LEVELS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 32;
    localparam int TOT_W    = 40;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 128;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REDUCE = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // Classified command between the front and the back
    typedef struct packed {
        logic               is_add;
        logic               is_reduce;
        logic               is_remove;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0]         status;
        logic [CNT_W-1:0]   ask_cnt;
        logic [CNT_W-1:0]   bid_cnt;
        logic [PRICE_W-1:0] top_ask;
        logic               ask_valid;
        logic [PRICE_W-1:0] top_bid;
        logic               bid_valid;
        logic [TOT_W-1:0]   level_qty;
    } result_t;

endpackage

/* hdl/plob_front.sv */
// Input side: two-entry command queue that decodes each accepted item.
module plob_front
    import plob_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_action,
    input  logic            in_side,
    input  logic [PRICE_W-1:0] in_price,
    input  logic [QTY_W-1:0]   in_qty,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output cmd_t            cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    cmd_t       dec;

    // Decode the action into command flags
    always_comb
    begin
        dec.is_add    = 1'b0;
        dec.is_reduce = 1'b0;
        dec.is_remove = 1'b0;
        unique case (in_action)
            ACT_ADD:    dec.is_add    = 1'b1;
            ACT_REDUCE: dec.is_reduce = 1'b1;
            ACT_REMOVE: dec.is_remove = 1'b1;
            default:    ;
        endcase
        dec.side  = in_side;
        dec.price = in_price;
        dec.qty   = in_qty;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = cmd_valid & cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Advance the queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overfilled");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count lost a transfer");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");

endmodule

/* hdl/plob_back.sv */
// Execution side: two sorted chains of level cells, compare then shift/update.
module plob_back
    import plob_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic [PRICE_W-1:0] price_reg [2][LEVELS];
    logic [PRICE_W-1:0] price_next [2][LEVELS];
    logic [TOT_W-1:0]   tot_reg [2][LEVELS];
    logic [TOT_W-1:0]   tot_next [2][LEVELS];
    logic [CNT_W-1:0]   cnt_reg [2];
    logic [CNT_W-1:0]   cnt_next [2];

    logic               phase_reg;
    cmd_t               cur_reg;
    logic [LEVELS-1:0]  match_reg, ahead_reg;
    logic [LEVELS-1:0]  match_c, ahead_c, valid_c;
    logic [TOT_W-1:0]   mtot_c, mtot_reg;
    logic               out_valid_reg;
    result_t            out_reg, out_next;
    logic               take, fire;

    logic [TOT_W:0]     sum;
    logic [TOT_W-1:0]   sat, diff, new_tot, lq;
    logic               do_ins, do_del, do_upd, hit, full, sd;
    logic [1:0]         st;
    logic [LEVELS-1:0]  sh, dm;

    assign cmd_ready = ~phase_reg;
    assign take      = cmd_valid & ~phase_reg;
    assign fire      = phase_reg & (~out_valid_reg | res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Compare the item's price against every cell of its side
    always_comb
    begin
        mtot_c = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            valid_c[i] = (CNT_W'(i) < cnt_reg[cmd.side]);
            match_c[i] = valid_c[i] & (price_reg[cmd.side][i] == cmd.price);
            ahead_c[i] = valid_c[i] & (cmd.side ? (cmd.price < price_reg[cmd.side][i])
                                                : (cmd.price > price_reg[cmd.side][i]));
            mtot_c     = mtot_c | (tot_reg[cmd.side][i] & {TOT_W{match_c[i]}});
        end
    end

    // Work out the update and the new chain contents
    always_comb
    begin
        sd      = cur_reg.side;
        hit     = |match_reg;
        full    = (cnt_reg[sd] == CNT_W'(LEVELS));
        sum     = {1'b0, mtot_reg} + {{(TOT_W+1-QTY_W){1'b0}}, cur_reg.qty};
        sat     = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
        diff    = mtot_reg - {{(TOT_W-QTY_W){1'b0}}, cur_reg.qty};
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_upd  = 1'b0;
        new_tot = sat;
        lq      = '0;
        st      = ST_OK;
        if (cur_reg.is_add)
        begin
            if (hit)
            begin
                do_upd = 1'b1;
                lq     = sat;
            end
            else if (full)
            begin
                st = ST_FULL;
            end
            else
            begin
                do_ins = 1'b1;
                lq     = {{(TOT_W-QTY_W){1'b0}}, cur_reg.qty};
            end
        end
        else if (cur_reg.is_reduce)
        begin
            if (!hit)
            begin
                st = ST_ABSENT;
            end
            else if ({{(TOT_W-QTY_W){1'b0}}, cur_reg.qty} >= mtot_reg)
            begin
                do_del = 1'b1;
            end
            else
            begin
                do_upd  = 1'b1;
                new_tot = diff;
                lq      = diff;
            end
        end
        else if (cur_reg.is_remove)
        begin
            if (!hit) st = ST_ABSENT;
            else do_del = 1'b1;
        end
        else
        begin
            lq = hit ? mtot_reg : '0;
        end

        for (int i = 0; i < LEVELS; i++)
        begin
            sh[i] = ahead_reg[i] | ~(CNT_W'(i) < cnt_reg[sd]);
            dm[i] = ahead_reg[i] | match_reg[i];
        end

        price_next = price_reg;
        tot_next   = tot_reg;
        cnt_next   = cnt_reg;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (do_ins && sh[i])
            begin
                if (i == 0 || !sh[(i == 0) ? 0 : i-1])
                begin
                    price_next[sd][i] = cur_reg.price;
                    tot_next[sd][i]   = {{(TOT_W-QTY_W){1'b0}}, cur_reg.qty};
                end
                else
                begin
                    price_next[sd][i] = price_reg[sd][(i == 0) ? 0 : i-1];
                    tot_next[sd][i]   = tot_reg[sd][(i == 0) ? 0 : i-1];
                end
            end
            else if (do_del && dm[i] && i < LEVELS-1)
            begin
                price_next[sd][i] = price_reg[sd][(i < LEVELS-1) ? i+1 : i];
                tot_next[sd][i]   = tot_reg[sd][(i < LEVELS-1) ? i+1 : i];
            end
            else if (do_upd && match_reg[i])
            begin
                tot_next[sd][i] = new_tot;
            end
        end
        if (do_ins) cnt_next[sd] = cnt_reg[sd] + CNT_W'(1);
        if (do_del) cnt_next[sd] = cnt_reg[sd] - CNT_W'(1);

        out_next.level_qty = lq;
        out_next.status    = st;
        out_next.bid_cnt   = cnt_next[0];
        out_next.ask_cnt   = cnt_next[1];
        out_next.bid_valid = (cnt_next[0] != '0);
        out_next.ask_valid = (cnt_next[1] != '0);
        out_next.top_bid   = out_next.bid_valid ? price_next[0][0] : '0;
        out_next.top_ask   = out_next.ask_valid ? price_next[1][0] : '0;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
        end
        else
        begin
            if (take) phase_reg <= 1'b1;
            else if (fire) phase_reg <= 1'b0;
            if (fire) out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
            if (fire) cnt_reg <= cnt_next;
        end
    end

    // Hold compare results, cells and the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg   <= cmd;
            match_reg <= match_c;
            ahead_reg <= ahead_c;
            mtot_reg  <= mtot_c;
        end
        if (fire)
        begin
            price_reg <= price_next;
            tot_reg   <= tot_next;
            out_reg   <= out_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_W'(LEVELS) && cnt_reg[1] <= CNT_W'(LEVELS))
        else $error("level count beyond table size");
    a_match_one: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> $onehot0(match_reg))
        else $error("price found in two cells");
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && out_next.status == ST_FULL) |-> (cnt_reg[cur_reg.side] == CNT_W'(LEVELS)))
        else $error("full status on a side with room");
    a_hold_res: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |=> $stable(out_reg))
        else $error("result changed under stall");

endmodule

/* hdl/price_level_order_book_core.sv */
// Top level of the price-level order book core.
//
// Keeps sorted bid (highest first) and ask (lowest first) price levels,
// up to 64 per side, each with a saturating 40-bit total.
// Input stream s_*: one transfer per action (add, reduce, remove, query).
// Output stream m_*: exactly one result transfer per input, in order,
// carrying the level total, top bid/ask, both counts and a status.
// A two-entry queue decouples input from the execution stage.
// Execution works on one item at a time: it first compares the price against
// all 64 cells of the side, then shifts/updates the cell chain and loads
// the result register; it takes the next item only after that load. An input
// passes the queue, the compare registers and the result register to m_*.
// Reset clears both level counts, the queue and the result valid flag.
// While m_tready is low the result holds, one more item waits in the
// execution stage, the queue fills with two more and s_tready drops.
module price_level_order_book_core
    import plob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[1:0], side[2], price[34:3], qty[66:35]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // level_quantity[39:0], bid_valid[40],
                                        // top bid price[72:41], ask_valid[73],
                                        // top ask price[105:74], bid_level_count[112:106],
                                        // ask_level_count[119:113], status[121:120]
);

    cmd_t    cmd;
    logic    cmd_valid, cmd_ready;
    result_t res;

    plob_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tdata[1:0]),
        .in_side   (s_tdata[2]),
        .in_price  (s_tdata[34:3]),
        .in_qty    (s_tdata[66:35]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    plob_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack result fields, lowest first
    assign m_tdata = OUT_W'(res);

endmodule

/* tb/sv/price_level_order_book_core_chk.sv */
// Checker of the order book core: watches both streams, predicts each result and compares it.
module price_level_order_book_core_chk
    import plob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[1:0], side[2], price[34:3], qty[66:35]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // level_quantity, bid_valid, top bid price, ask_valid,
                                        // top ask price, bid_level_count, ask_level_count, status
    output int               fail_count,
    output int               pending,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Expected book image after one transfer
    typedef struct {
        logic [TOT_W-1:0]   lq;
        logic               bv;
        logic [PRICE_W-1:0] bb;
        logic               av;
        logic [PRICE_W-1:0] ba;
        logic [6:0]         bc;
        logic [6:0]         ac;
        logic [1:0]         st;
    } book_view_t;

    // Shadow copy of both sides of the book
    logic [PRICE_W-1:0] lvl_price [2][LEVELS];
    logic [TOT_W-1:0]   lvl_total [2][LEVELS];
    int                 lvl_cnt   [2];

    book_view_t         view_q[$];

    function automatic int find_level(input int sd, input logic [PRICE_W-1:0] p);
        for (int i = 0; i < lvl_cnt[sd]; i++)
            if (lvl_price[sd][i] == p) return i;
        return -1;
    endfunction

    function automatic void drop_level(input int sd, input int idx);
        for (int i = idx; i + 1 < lvl_cnt[sd]; i++)
        begin
            lvl_price[sd][i] = lvl_price[sd][i+1];
            lvl_total[sd][i] = lvl_total[sd][i+1];
        end
        lvl_cnt[sd]--;
    endfunction

    // Apply one order action to the shadow book and return the resulting view
    function automatic book_view_t apply_order(input logic [1:0] act, input int sd,
                                               input logic [PRICE_W-1:0] p,
                                               input logic [QTY_W-1:0] q);
        book_view_t v;
        int         idx;
        int         pos;
        logic [TOT_W:0] sum;
        v.st = ST_OK;
        idx  = find_level(sd, p);
        case (act)
            ACT_ADD:
            begin
                if (idx >= 0)
                begin
                    sum = {1'b0, lvl_total[sd][idx]} + (TOT_W+1)'(q);
                    lvl_total[sd][idx] = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
                end
                else if (lvl_cnt[sd] >= LEVELS)
                    v.st = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < lvl_cnt[sd] &&
                           !(sd ? (p < lvl_price[sd][pos]) : (p > lvl_price[sd][pos])))
                        pos++;
                    for (int i = lvl_cnt[sd]; i > pos; i--)
                    begin
                        lvl_price[sd][i] = lvl_price[sd][i-1];
                        lvl_total[sd][i] = lvl_total[sd][i-1];
                    end
                    lvl_price[sd][pos] = p;
                    lvl_total[sd][pos] = TOT_W'(q);
                    lvl_cnt[sd]++;
                end
            end
            ACT_REDUCE:
            begin
                if (idx < 0)
                    v.st = ST_ABSENT;
                else if (TOT_W'(q) >= lvl_total[sd][idx])
                    drop_level(sd, idx);
                else
                    lvl_total[sd][idx] = lvl_total[sd][idx] - TOT_W'(q);
            end
            ACT_REMOVE:
            begin
                if (idx < 0)
                    v.st = ST_ABSENT;
                else
                    drop_level(sd, idx);
            end
            default: ;
        endcase
        idx  = find_level(sd, p);
        v.lq = (idx >= 0) ? lvl_total[sd][idx] : '0;
        v.bv = lvl_cnt[0] > 0;
        v.bb = (lvl_cnt[0] > 0) ? lvl_price[0][0] : '0;
        v.av = lvl_cnt[1] > 0;
        v.ba = (lvl_cnt[1] > 0) ? lvl_price[1][0] : '0;
        v.bc = lvl_cnt[0][6:0];
        v.ac = lvl_cnt[1][6:0];
        return v;
    endfunction

    function automatic void report(input string fname, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        if (fail_count < 10)
            $display("%t mismatch on result %0d, %s: expected %0h got %0h",
                     $realtime, checked, fname, exp_v, got_v);
        fail_count++;
    endfunction

    // Predict on every input transfer, compare on every output transfer
    always @(posedge clk or negedge rst_n)
    begin
        book_view_t       e;
        logic [127:0]     r;
        if (!rst_n)
        begin
            lvl_cnt[0] = 0;
            lvl_cnt[1] = 0;
            view_q.delete();
            pending    = 0;
            fail_count = 0;
            checked    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                view_q.push_back(apply_order(s_tdata[1:0], int'(s_tdata[2]),
                                             s_tdata[34:3], s_tdata[66:35]));
            if (m_tvalid && m_tready)
            begin
                if (view_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%t result transfer with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    e = view_q.pop_front();
                    r = 128'(m_tdata);
                    if (r[39:0]    !== e.lq) report("level_quantity", 64'(e.lq), 64'(r[39:0]));
                    if (r[40]      !== e.bv) report("bid_valid", 64'(e.bv), 64'(r[40]));
                    if (r[72:41]   !== e.bb) report("top bid price", 64'(e.bb), 64'(r[72:41]));
                    if (r[73]      !== e.av) report("ask_valid", 64'(e.av), 64'(r[73]));
                    if (r[105:74]  !== e.ba) report("top ask price", 64'(e.ba), 64'(r[105:74]));
                    if (r[112:106] !== e.bc) report("bid_level_count", 64'(e.bc),
                                                    64'(r[112:106]));
                    if (r[119:113] !== e.ac) report("ask_level_count", 64'(e.ac),
                                                    64'(r[119:113]));
                    if (r[121:120] !== e.st) report("status", 64'(e.st), 64'(r[121:120]));
                end
                checked <= checked + 1;
            end
            pending = view_q.size();
        end
    end

endmodule

/* tb/sv/price_level_order_book_core_tb.sv */
// Top of the order book testbench: clock, reset, stimulus, receiver stalls and the verdict.
module price_level_order_book_core_tb
    import plob_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // action[1:0], side[2], price[34:3], qty[66:35]
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // level_quantity, bid_valid, top bid price, ask_valid,
                                 // top ask price, bid_level_count, ask_level_count, status
    int               fail_count;
    int               pending;
    int               checked;
    int               sent_cnt;
    int               burst_left;
    logic             stim_done;
    logic [PRICE_W-1:0] price_pool[2][$];

    price_level_order_book_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    price_level_order_book_core_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Count accepted input transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sent_cnt <= 0;
        else if (s_tvalid && s_tready)
            sent_cnt <= sent_cnt + 1;
    end

    // Offer one order and hold it until transferred; idle between bursts
    task automatic send_order(input logic [1:0] act, input logic sd,
                              input logic [PRICE_W-1:0] p, input logic [QTY_W-1:0] q);
        int target;
        target   = sent_cnt + 1;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, q, p, sd, act};
        do @(negedge clk); while (sent_cnt < target);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic logic [QTY_W-1:0] pick_qty();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {QTY_W{1'b1}};
            2, 3:    return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PRICE_W-1:0] pick_price(input int sd);
        int n;
        n = price_pool[sd].size();
        if (n > 0 && $urandom_range(0, 4) != 0)
            return price_pool[sd][$urandom_range(0, n - 1)];
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return {PRICE_W{1'b1}};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_order(input logic sd, input logic [PRICE_W-1:0] p,
                             input logic [QTY_W-1:0] q);
        price_pool[sd].push_back(p);
        if (price_pool[sd].size() > 90)
            price_pool[sd].delete($urandom_range(0, 89));
        send_order(ACT_ADD, sd, p, q);
    endtask

    task automatic rand_order(input logic [1:0] act, input logic sd);
        send_order(act, sd, pick_price(int'(sd)), pick_qty());
    endtask

    // Receiver: random stalls, one long hold-off so the core backs up
    initial
    begin
        int held;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (300)
        begin
            @(negedge clk);
            m_tready <= $urandom_range(0, 3) != 0;
        end
        @(negedge clk);
        m_tready <= 1'b0;
        held = 0;
        while (held < 400)
        begin
            @(negedge clk);
            held++;
        end
        forever
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(negedge clk);
                end
                1:
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(negedge clk);
                end
                default:
                    repeat ($urandom_range(5, 30))
                    begin
                        m_tready <= $urandom_range(0, 1);
                        @(negedge clk);
                    end
            endcase
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [PRICE_W-1:0] p;
        logic               sd;
        int                 wait_cnt;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        stim_done  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty book, extremes, every action, edge totals
        send_order(ACT_QUERY,  1'b0, '0, '0);
        send_order(ACT_REMOVE, 1'b1, 32'h1234, '0);
        send_order(ACT_REDUCE, 1'b0, 32'h1234, 32'd5);
        send_order(ACT_ADD,    1'b0, '0, '0);
        send_order(ACT_ADD,    1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(ACT_ADD,    1'b1, 32'hFFFF_FFFF, 32'd7);
        send_order(ACT_ADD,    1'b1, '0, 32'd5);
        send_order(ACT_ADD,    1'b0, 32'd100, 32'd10);
        send_order(ACT_ADD,    1'b0, 32'd100, 32'd20);
        send_order(ACT_REDUCE, 1'b0, 32'd100, 32'd5);
        send_order(ACT_REDUCE, 1'b0, 32'd100, 32'd25);
        send_order(ACT_ADD,    1'b1, 32'd200, 32'd3);
        send_order(ACT_REDUCE, 1'b1, 32'd200, 32'hFFFF_FFFF);
        send_order(ACT_QUERY,  1'b1, 32'd200, '0);
        send_order(ACT_QUERY,  1'b0, 32'hFFFF_FFFF, '0);
        send_order(ACT_REMOVE, 1'b1, 32'hFFFF_FFFF, '0);
        send_order(ACT_REMOVE, 1'b1, 32'hFFFF_FFFF, '0);
        send_order(ACT_REDUCE, 1'b0, '0, '0);
        send_order(ACT_ADD,    1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
        send_order(ACT_ADD,    1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
        send_order(ACT_REMOVE, 1'b0, 32'hAAAA_AAAA, 32'd1);

        // hammer one level until its total saturates
        sd = $urandom_range(0, 1);
        p  = $urandom;
        repeat (260) send_order(ACT_ADD, sd, p, 32'hFFFF_FFFF);
        send_order(ACT_REDUCE, sd, p, 32'd1);
        send_order(ACT_ADD, sd, p, 32'd9);
        send_order(ACT_REMOVE, sd, p, '0);

        // fill the ask side past its limit
        repeat (68) add_order(1'b1, $urandom, pick_qty());

        // random sequences: fills, mixed trading, drains, noise
        while (sent_cnt < 550)
        begin
            sd = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0, 1:
                    repeat ($urandom_range(40, 75)) add_order(sd, $urandom, pick_qty());
                2, 3, 4, 5, 6:
                    repeat ($urandom_range(10, 30))
                    begin
                        sd = $urandom_range(0, 1);
                        case ($urandom_range(0, 5))
                            0, 1: add_order(sd, pick_price(int'(sd)), pick_qty());
                            2:    rand_order(ACT_REDUCE, sd);
                            3:    rand_order(ACT_REMOVE, sd);
                            default: rand_order(ACT_QUERY, sd);
                        endcase
                    end
                7:
                    repeat ($urandom_range(20, 60))
                        rand_order(($urandom_range(0, 1) != 0) ? ACT_REMOVE : ACT_REDUCE, sd);
                default:
                    repeat ($urandom_range(3, 10))
                        send_order(2'($urandom), 1'($urandom), $urandom, $urandom);
            endcase
        end
        s_tvalid  <= 1'b0;
        stim_done = 1'b1;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (20) @(negedge clk);

        $display("Sent %0d orders (directed, saturation, fills past 64 levels, random mixes),",
                 sent_cnt);
        $display("checked %0d results with %0d still expected and %0d mismatches.",
                 checked, pending, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS price_level_order_book_core");
        else
            $display("FAIL price_level_order_book_core");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("FAIL price_level_order_book_core");
        $finish;
    end

endmodule
